### design/assert_macros.svh
// Assertion macros of the priority queue, included by the core module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define APQ_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define APQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/apq_pkg.sv
// Types, constants and the ranking function of the array priority queue.
package apq_pkg;

    localparam int QUEUE_DEPTH   = 64;
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W        = 32;
    localparam int ENTRY_COUNT_W = 7;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_PEEK    = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [DATA_W-1:0] item_value;
        logic signed [DATA_W-1:0] item_priority;
    } in_item_t;

    typedef struct packed {
        logic                        top_valid;
        logic signed [DATA_W-1:0]    top_value;
        logic signed [DATA_W-1:0]    top_priority;
        logic [ENTRY_COUNT_W-1:0]    entry_count;
        logic [1:0]                  status;
    } out_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] ent_value;
        logic signed [DATA_W-1:0] ent_prio;
    } entry_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctrl_t;

    // True when a is served strictly before b.
    function automatic logic ranks_above(input entry_t a, input entry_t b);
        logic res;
        begin
            res = (a.ent_prio > b.ent_prio) ||
                  ((a.ent_prio == b.ent_prio) && (a.ent_value > b.ent_value));
            return res;
        end
    endfunction

endpackage

### design/apq_cell.sv
// One cell of the sorted chain: holds an entry and moves it along on insert or remove.
module apq_cell (
    input  logic                aclk,
    input  apq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  apq_pkg::entry_t     new_entry,
    input  apq_pkg::entry_t     left_entry,
    input  logic                left_keep,
    input  apq_pkg::entry_t     right_entry,
    output logic                keep,
    output apq_pkg::entry_t     entry,
    output apq_pkg::entry_t     entry_next
);
    import apq_pkg::*;

    entry_t entry_reg;

    // An occupied cell whose entry ranks at least as high as the new one stays put,
    // so that an equal entry stored earlier stays ahead of the new one.
    always_comb begin
        keep       = occupied && !ranks_above(new_entry, entry_reg);
        entry_next = entry_reg;
        if (ctrl.insert) begin
            if (!keep) begin
                entry_next = left_keep ? new_entry : left_entry;
            end
        end else if (ctrl.remove) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

### design/array_priority_queue_core.sv
// Array priority queue: a sorted chain of cells with the top entry always in the first cell.
// The result of a command is registered and presented in the cycle after its input transfer.
// Throughput: one command per cycle while results are taken as soon as they appear.
// A command is taken only when the output register is empty or is emptied in that cycle.
// Reset (aresetn low, synchronous) empties the queue and drops any pending result.
`include "assert_macros.svh"

module array_priority_queue_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  apq_pkg::in_item_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output apq_pkg::out_item_t m_data
);
    import apq_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    out_item_t        m_data_reg;
    out_item_t        m_data_next;

    logic             accept;
    logic             full;
    logic             empty;
    cell_ctrl_t       ctrl;
    status_t          status;
    entry_t           new_entry;

    entry_t           cell_entry [QUEUE_DEPTH];
    entry_t           cell_next  [QUEUE_DEPTH];
    logic             cell_keep  [QUEUE_DEPTH];

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign new_entry = '{ent_value: s_data.item_value, ent_prio: s_data.item_priority};

    always_comb begin
        ctrl       = '0;
        status     = ST_DONE;
        count_next = count_reg;
        case (cmd_t'(s_data.command))
            CMD_ENQUEUE: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    ctrl.insert = accept;
                end
            end
            CMD_DEQUEUE: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    ctrl.remove = accept;
                end
            end
            default: begin
                status = ST_DONE;
            end
        endcase
        if (ctrl.insert) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.remove) begin
            count_next = count_reg - 1'b1;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic   occ;
            entry_t left_e;
            entry_t right_e;
            logic   left_k;

            assign occ = (count_reg > CNT_W'(gi));

            if (gi == 0) begin : g_first
                assign left_e = new_entry;
                assign left_k = 1'b1;
            end else begin : g_mid
                assign left_e = cell_entry[gi-1];
                assign left_k = cell_keep[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_last
                assign right_e = cell_entry[gi];
            end else begin : g_inner
                assign right_e = cell_entry[gi+1];
            end

            apq_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .occupied    (occ),
                .new_entry   (new_entry),
                .left_entry  (left_e),
                .left_keep   (left_k),
                .right_entry (right_e),
                .keep        (cell_keep[gi]),
                .entry       (cell_entry[gi]),
                .entry_next  (cell_next[gi])
            );
        end
    endgenerate

    always_comb begin
        m_data_next = m_data_reg;
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next             = 1'b1;
            m_data_next.top_valid    = (count_next != '0);
            m_data_next.top_value    = (count_next != '0) ? cell_next[0].ent_value : '0;
            m_data_next.top_priority = (count_next != '0) ? cell_next[0].ent_prio : '0;
            m_data_next.entry_count  = ENTRY_COUNT_W'(count_next);
            m_data_next.status       = status;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `APQ_ASSERT_ALWAYS(a_count_bound, aclk, !aresetn || (count_reg <= CNT_W'(QUEUE_DEPTH)),
        "count above depth")
    `APQ_ASSERT(a_full_refused, aclk, aresetn,
        accept && full && (s_data.command == CMD_ENQUEUE) |=>
        (count_reg == $past(count_reg)) && (m_data.status == ST_FULL),
        "enqueue when full not refused")
    `APQ_ASSERT(a_dequeue_count, aclk, aresetn,
        accept && !empty && (s_data.command == CMD_DEQUEUE) |=>
        count_reg == $past(count_reg) - 1'b1,
        "dequeue did not lower the count")
    `APQ_ASSERT(a_top_valid, aclk, aresetn,
        m_valid |-> (m_data.top_valid == (m_data.entry_count != '0)),
        "top valid disagrees with count")

endmodule
